// ===== hdl/lfscd_pkg.sv =====
// shared types and constants for the length-framed sum-checked deframer
// no dependencies; compiled first
package lfscd_pkg;

   localparam logic [7:0] HEADER_BYTE   = 8'hFF;
   localparam int         QUEUE_DEPTH   = 2;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_BAD     = 2'd2
   } kind_type;

   // front parser states, one-hot
   typedef enum logic [3:0] {
      ST_WAIT_HDR = 4'b0001,
      ST_GET_ID   = 4'b0010,
      ST_GET_LEN  = 4'b0100,
      ST_GET_BODY = 4'b1000
   } front_state_type;

   // classified work passed from front to back
   typedef struct packed {
      logic       is_check;   // checksum byte, else payload byte
      logic       first;      // first payload byte of the frame: sum restarts
      logic       empty;      // checksum of a zero-length frame
      logic [7:0] data;
      logic [7:0] unit_id;
      logic [7:0] frame_length;
      logic [7:0] byte_index;
   } cmd_type;

endpackage

// ===== hdl/lfscd_req_if.sv =====
// input channel: one received byte per transaction
// depends on nothing
interface lfscd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/lfscd_rsp_if.sv =====
// result channel: payload bytes and frame verdicts
// depends on nothing
interface lfscd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] out_kind;
   logic [7:0] byte_value;
   logic [7:0] unit_id;
   logic [7:0] frame_length;
   logic [7:0] byte_index;

   modport source (output valid, output out_kind, output byte_value, output unit_id,
                   output frame_length, output byte_index, input ready);
   modport sink   (input valid, input out_kind, input byte_value, input unit_id,
                   input frame_length, input byte_index, output ready);
endinterface

// ===== hdl/lfscd_front.sv =====
// front end: header/id/length/body parser, classifies each byte
// depends on lfscd_pkg and lfscd_req_if
module lfscd_front (
   input  logic               clock,
   input  logic               reset,
   lfscd_req_if.sink          req,
   input  logic               queue_full,
   output logic               push,
   output lfscd_pkg::cmd_type push_data
);
   import lfscd_pkg::*;

   front_state_type state_ff, state_in;
   logic [7:0]      id_ff, id_in;
   logic [7:0]      len_ff, len_in;
   logic [7:0]      cnt_ff, cnt_in;
   logic            accept;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      state_in  = state_ff;
      id_in     = id_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      push      = 1'b0;
      push_data = '{is_check: 1'b0, first: (cnt_ff == 8'd0), empty: (len_ff == 8'd0),
                    data: req.rx_byte, unit_id: id_ff, frame_length: len_ff,
                    byte_index: cnt_ff};
      if (accept) begin
         if (req.rx_byte == HEADER_BYTE) begin
            state_in = ST_GET_ID;
            id_in    = 8'd0;
            len_in   = 8'd0;
            cnt_in   = 8'd0;
         end else begin
            case (state_ff)
               ST_WAIT_HDR: begin
               end
               ST_GET_ID: begin
                  id_in    = req.rx_byte;
                  state_in = ST_GET_LEN;
               end
               ST_GET_LEN: begin
                  len_in   = req.rx_byte;
                  cnt_in   = 8'd0;
                  state_in = ST_GET_BODY;
               end
               ST_GET_BODY: begin
                  push = 1'b1;
                  if (cnt_ff < len_ff) begin
                     cnt_in = cnt_ff + 8'd1;
                  end else begin
                     push_data.is_check   = 1'b1;
                     push_data.byte_index = 8'd0;
                     state_in             = ST_WAIT_HDR;
                  end
               end
               default: begin
                  state_in = ST_WAIT_HDR;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WAIT_HDR;
         id_ff    <= 8'd0;
         len_ff   <= 8'd0;
         cnt_ff   <= 8'd0;
      end else begin
         state_ff <= state_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== hdl/lfscd_queue.sv =====
// short register queue between parser and checker
// depends on lfscd_pkg
module lfscd_queue #(
   parameter int DEPTH = lfscd_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lfscd_pkg::cmd_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output lfscd_pkg::cmd_type pop_data
);
   import lfscd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cmd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == FULL_CNT);
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count beyond depth");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("pop did not drain queue");

endmodule

// ===== hdl/lfscd_back.sv =====
// back end: running sum, checksum verdict and output register
// depends on lfscd_pkg and lfscd_rsp_if
module lfscd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  lfscd_pkg::cmd_type cmd,
   output logic               pop,
   lfscd_rsp_if.source        rsp
);
   import lfscd_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] sum_ff, sum_in;
   kind_type   kind_ff, kind_in;
   logic [7:0] value_ff, id_ff, len_ff, idx_ff;
   logic [7:0] expect_sum;

   assign pop        = cmd_valid && (!valid_ff || rsp.ready);
   assign expect_sum = cmd.empty ? 8'd0 : sum_ff;

   always_comb begin
      valid_in = valid_ff;
      sum_in   = sum_ff;
      kind_in  = kind_ff;
      if (valid_ff && rsp.ready) begin
         valid_in = 1'b0;
      end
      if (pop) begin
         valid_in = 1'b1;
         if (cmd.is_check) begin
            kind_in = (cmd.data == expect_sum) ? KIND_GOOD : KIND_BAD;
         end else begin
            kind_in = KIND_PAYLOAD;
            sum_in  = cmd.first ? cmd.data : sum_ff + cmd.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sum_ff   <= 8'd0;
      end else begin
         valid_ff <= valid_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      if (pop) begin
         value_ff <= cmd.data;
         id_ff    <= cmd.unit_id;
         len_ff   <= cmd.frame_length;
         idx_ff   <= cmd.byte_index;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.out_kind     = kind_ff;
   assign rsp.byte_value   = value_ff;
   assign rsp.unit_id      = id_ff;
   assign rsp.frame_length = len_ff;
   assign rsp.byte_index   = idx_ff;

endmodule

// ===== hdl/length_framed_sum_checked_deframer.sv =====
// length-framed sum-checked deframer: 0xFF header, id, length, payload, checksum
// path: each result goes from its accepted byte through a queue entry and then the output register to rsp
// throughput: one byte per cycle while the queue has room; a stalled rsp fills the queue and stalls req
// reset: synchronous, active high; parser waits for a header, queue and output empty
// depends on lfscd_pkg, lfscd_req_if, lfscd_rsp_if, lfscd_front, lfscd_queue, lfscd_back
module length_framed_sum_checked_deframer #(
   parameter int QUEUE_DEPTH = lfscd_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   lfscd_req_if.sink  req,
   lfscd_rsp_if.source rsp
);
   import lfscd_pkg::*;

   // front to queue
   logic    push;
   cmd_type push_data;
   logic    queue_full;

   // queue to back
   logic    pop;
   logic    pop_valid;
   cmd_type pop_data;

   // parser: tracks frame position, drops stray bytes, tags payload and checksum
   // transactions; stalls the input only when the queue is full
   lfscd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   // decoupling queue so a stalled result side does not block parsing at once
   lfscd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   // checker: keeps the running sum, gives the verdict at the checksum byte and
   // holds the result in an output register until taken
   lfscd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd       (pop_data),
      .pop       (pop),
      .rsp       (rsp)
   );

endmodule
